@@ rtl/ccsd_pkg.sv @@
`default_nettype none

package ccsd_pkg;

  // field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COEF_W    = 12;
  localparam int unsigned LOG_N_W   = 4;
  localparam int unsigned SIG_LEN_W = 12;
  localparam int unsigned MAG_W     = 11;

  // configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // register indexes (word address)
  localparam logic [1:0] REG_LOG_N     = 2'd0;
  localparam logic [1:0] REG_SIG_LEN   = 2'd1;
  localparam logic [1:0] REG_MAG_BOUND = 2'd2;

  // register reset values
  localparam logic [LOG_N_W-1:0]   LOG_N_RST     = 4'd9;
  localparam logic [SIG_LEN_W-1:0] SIG_LEN_RST   = 12'd625;
  localparam logic [MAG_W-1:0]     MAG_BOUND_RST = 11'd2047;

  // default for the largest supported log_n
  localparam int unsigned MAX_LOG_N_DEF = 10;

  // bit-level decode state carried between beats
  typedef struct packed {
    logic [7:0] bits;   // unconsumed bits, or pending sign and low magnitude
    logic [2:0] cnt;    // number of unconsumed bits
    logic       extra;  // unary run still open, next beat must close it
    logic       err;    // sticky reject
  } ccsd_bits_t;

  // one result beat
  typedef struct packed {
    logic                     coef_valid;
    logic signed [COEF_W-1:0] coef_value;
    logic                     rejected;
    logic                     msg_done;
  } ccsd_res_t;

  // trailing zero count of an eight-bit value
  function automatic logic [2:0] tz8(input logic [7:0] v);
    logic [2:0] k;
    k = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        k = 3'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ccsd_in_if.sv @@
`default_nettype none

interface ccsd_in_if import ccsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/ccsd_out_if.sv @@
`default_nettype none

interface ccsd_out_if import ccsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     coef_valid;
  logic signed [COEF_W-1:0] coef_value;
  logic                     rejected;
  logic                     msg_done;

  modport source (output valid, output coef_valid, output coef_value,
                  output rejected, output msg_done, input ready);
  modport sink (input valid, input coef_valid, input coef_value,
                input rejected, input msg_done, output ready);
endinterface

`default_nettype wire

@@ rtl/ccsd_step.sv @@
`default_nettype none

module ccsd_step import ccsd_pkg::*; #(
  parameter int unsigned MAX_LOG_N = MAX_LOG_N_DEF
) (
  input  wire logic [LOG_N_W-1:0] log_n_i,
  input  wire logic [MAG_W-1:0]   mag_bound_i,
  input  wire logic [BYTE_W-1:0]  byte_i,
  input  wire logic               last_i,
  input  wire ccsd_bits_t         st_i,
  input  wire logic [MAX_LOG_N:0] cnt_i,
  output ccsd_bits_t              st_o,
  output logic [MAX_LOG_N:0]      cnt_o,
  output ccsd_res_t               res_o
);

  localparam int unsigned CW = MAX_LOG_N + 1;

  logic [LOG_N_W-1:0] ln;
  logic [CW-1:0]      n;
  logic [14:0]        wide;
  logic [7:0]         rest;
  logic [2:0]         tzr;
  logic [3:0]         hi;
  logic [3:0]         rest_len;
  logic [3:0]         cnt4;
  logic [7:0]         remain;
  logic               sign;
  logic [6:0]         mag7;
  logic [MAG_W-1:0]   mag;
  logic [COEF_W-1:0]  mag_ext;
  logic               have;

  // coefficient count per signature, log_n clamped to the supported maximum
  assign ln = (log_n_i > LOG_N_W'(MAX_LOG_N)) ? LOG_N_W'(MAX_LOG_N) : log_n_i;
  assign n  = CW'(1) << ln;

  // header assembly from leftover bits and the new beat
  assign wide = {8'b0, st_i.bits[6:0]} | ({7'b0, byte_i} << st_i.cnt);

  // sign, low magnitude and the bits holding the unary run
  always_comb begin
    if (st_i.extra) begin
      sign     = st_i.bits[0];
      mag7     = st_i.bits[7:1];
      rest     = byte_i;
      rest_len = 4'd8;
    end else begin
      sign     = wide[0];
      mag7     = wide[7:1];
      rest     = {1'b0, wide[14:8]};
      rest_len = {1'b0, st_i.cnt};
    end
  end

  // unary run length and what is left after its terminating one
  assign tzr     = tz8(rest);
  assign hi      = (st_i.extra ? {1'b0, st_i.cnt} : 4'd0) + {1'b0, tzr};
  assign mag     = {hi, mag7};
  assign mag_ext = {1'b0, mag};
  assign remain  = rest >> ({1'b0, tzr} + 4'd1);
  assign cnt4    = rest_len - {1'b0, tzr} - 4'd1;

  // next state and result
  always_comb begin
    st_o              = st_i;
    cnt_o             = cnt_i;
    have              = 1'b0;
    res_o.coef_valid  = 1'b0;
    res_o.coef_value  = '0;
    if (!st_i.err) begin
      if (cnt_i < n) begin
        if (st_i.extra) begin
          st_o.extra = 1'b0;
          if (byte_i == '0) begin
            st_o.err = 1'b1;
          end else begin
            have = 1'b1;
          end
        end else if (rest == '0) begin
          // run not closed on this beat, keep the header for the next one
          st_o.extra = 1'b1;
          st_o.bits  = wide[7:0];
        end else begin
          have = 1'b1;
        end
        if (have) begin
          if ((mag > mag_bound_i) || ((mag == '0) && sign)) begin
            st_o.err = 1'b1;
          end else begin
            st_o.bits        = remain;
            st_o.cnt         = cnt4[2:0];
            cnt_o            = cnt_i + CW'(1);
            res_o.coef_valid = 1'b1;
            res_o.coef_value = $signed(sign ? (COEF_W'(0) - mag_ext) : mag_ext);
            // leftover bits after the last coefficient must be zero
            if ((cnt_o == n) && (remain != '0)) begin
              st_o.err = 1'b1;
            end
          end
        end
      end else if (byte_i != '0) begin
        // padding must be zero
        st_o.err = 1'b1;
      end
    end
    // message ended short of coefficients
    if (last_i && (cnt_o < n)) begin
      st_o.err = 1'b1;
    end
    res_o.rejected = st_o.err;
    res_o.msg_done = last_i;
  end

endmodule

`default_nettype wire

@@ rtl/compressed_coef_stream_decoder.sv @@
// An accepted beat is held in the input register, then its result in the result register, which drives the output.
// Throughput: one byte per cycle while the receiver takes results; the decode of a byte is one pass of
// header shift, trailing-zero count and bound compare between the input and result registers.
// Reset (asynchronous, active low) empties both registers, clears the message state
// and loads log_n 9, sig_len 625, mag_bound 2047.
`default_nettype none

module compressed_coef_stream_decoder import ccsd_pkg::*; #(
  parameter int unsigned MAX_LOG_N = MAX_LOG_N_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ccsd_in_if.sink                byte_i,
  ccsd_out_if.source             coef_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned CW = MAX_LOG_N + 1;

  logic [LOG_N_W-1:0]   log_n_q;
  logic [SIG_LEN_W-1:0] sig_len_q;
  logic [MAG_W-1:0]     mag_bound_q;
  logic [1:0]           reg_idx;
  logic                 wr_en;

  logic                 in_vld_q;
  logic [BYTE_W-1:0]    in_byte_q;
  logic                 out_vld_q;
  ccsd_res_t            res_q;
  ccsd_res_t            res_d;
  ccsd_bits_t           st_q;
  ccsd_bits_t           st_d;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        cnt_d;
  logic [SIG_LEN_W-1:0] byte_cnt_q;
  logic [SIG_LEN_W-1:0] byte_cnt_inc;
  logic                 last;
  logic                 adv;
  logic                 in_acc;

  // configuration registers
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_n_q     <= LOG_N_RST;
      sig_len_q   <= SIG_LEN_RST;
      mag_bound_q <= MAG_BOUND_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LOG_N:     log_n_q     <= pwdata[LOG_N_W-1:0];
        REG_SIG_LEN:   sig_len_q   <= pwdata[SIG_LEN_W-1:0];
        REG_MAG_BOUND: mag_bound_q <= pwdata[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOG_N:     prdata = {{(APB_DW-LOG_N_W){1'b0}}, log_n_q};
      REG_SIG_LEN:   prdata = {{(APB_DW-SIG_LEN_W){1'b0}}, sig_len_q};
      REG_MAG_BOUND: prdata = {{(APB_DW-MAG_W){1'b0}}, mag_bound_q};
      default:       prdata = '0;
    endcase
  end

  // handshake: input stage moves on when the result register is free or drained
  assign adv          = in_vld_q && (!out_vld_q || coef_o.ready);
  assign byte_i.ready = !in_vld_q || adv;
  assign in_acc       = byte_i.valid && byte_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= byte_i.in_byte;
    end
  end

  // last beat of the message, byte counter wraps at 12 bits
  assign byte_cnt_inc = byte_cnt_q + SIG_LEN_W'(1);
  assign last         = (byte_cnt_inc == sig_len_q);

  // decode of one beat
  ccsd_step #(
    .MAX_LOG_N (MAX_LOG_N)
  ) u_step (
    .log_n_i     (log_n_q),
    .mag_bound_i (mag_bound_q),
    .byte_i      (in_byte_q),
    .last_i      (last),
    .st_i        (st_q),
    .cnt_i       (cnt_q),
    .st_o        (st_d),
    .cnt_o       (cnt_d),
    .res_o       (res_d)
  );

  // message state, cleared after the last beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      cnt_q      <= '0;
      byte_cnt_q <= '0;
    end else if (adv) begin
      if (last) begin
        st_q       <= '0;
        cnt_q      <= '0;
        byte_cnt_q <= '0;
      end else begin
        st_q       <= st_d;
        cnt_q      <= cnt_d;
        byte_cnt_q <= byte_cnt_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (coef_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign coef_o.valid      = out_vld_q;
  assign coef_o.coef_valid = res_q.coef_valid;
  assign coef_o.coef_value = res_q.coef_value;
  assign coef_o.rejected   = res_q.rejected;
  assign coef_o.msg_done   = res_q.msg_done;

  // a free result register never holds back the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> byte_i.ready)
    else $error("input stalled with an empty result register");

  // the last beat restarts the message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last |=> (byte_cnt_q == '0) && (cnt_q == '0) && !st_q.err)
    else $error("message state not cleared after the last beat");

  // a reject inside a message stays until its end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_d.rejected && !last |=> st_q.err)
    else $error("reject flag lost inside a message");

  // coefficient count never passes the largest signature size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (CW'(1) << MAX_LOG_N))
    else $error("coefficient count out of range");

endmodule

`default_nettype wire

@@ sim/tb_compressed_coef_stream_decoder.sv @@
`timescale 1ns / 100ps

module tb_compressed_coef_stream_decoder import ccsd_pkg::*; ();

  localparam int unsigned RANDOM_BEATS = 800;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned DIR_ROWS     = 37;

  typedef enum logic [1:0] {ROW_WRITE, ROW_BEAT, ROW_TYPED} row_kind_e;

  typedef enum int {
    FLAW_NONE, FLAW_NOISE, FLAW_MINUS_ZERO, FLAW_BIT_FLIP, FLAW_PADDING, FLAW_OVER_BOUND
  } flaw_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] reg_idx;
    logic [31:0] value;
    ccsd_res_t  res;
  } stim_row_t;

  localparam ccsd_res_t NO_RES = '0;

  // directed stimulus: register writes and beats, typed results where obvious
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // two coefficients in four bytes, clean message
    '{ROW_WRITE, REG_LOG_N,     32'd1,    NO_RES},
    '{ROW_WRITE, REG_SIG_LEN,   32'd4,    NO_RES},
    '{ROW_WRITE, REG_MAG_BOUND, 32'd2047, NO_RES},
    '{ROW_TYPED, 2'd0, 32'h0A, '{1'b0, 12'sd0, 1'b0, 1'b0}},
    '{ROW_TYPED, 2'd0, 32'h01, '{1'b1, 12'sd5, 1'b0, 1'b0}},
    '{ROW_BEAT,  2'd0, 32'h00, NO_RES},
    '{ROW_BEAT,  2'd0, 32'h01, NO_RES},
    // minus zero, then ignored bytes up to the end
    '{ROW_TYPED, 2'd0, 32'h01, '{1'b0, 12'sd0, 1'b0, 1'b0}},
    '{ROW_TYPED, 2'd0, 32'h01, '{1'b0, 12'sd0, 1'b1, 1'b0}},
    '{ROW_BEAT,  2'd0, 32'hFF, NO_RES},
    '{ROW_TYPED, 2'd0, 32'hFF, '{1'b0, 12'sd0, 1'b1, 1'b1}},
    // unary run not closed by the extra byte
    '{ROW_BEAT,  2'd0, 32'h0A, NO_RES},
    '{ROW_TYPED, 2'd0, 32'h00, '{1'b0, 12'sd0, 1'b1, 1'b0}},
    '{ROW_BEAT,  2'd0, 32'h00, NO_RES},
    '{ROW_BEAT,  2'd0, 32'h80, NO_RES},
    // bytes run out before the coefficients are done
    '{ROW_WRITE, REG_SIG_LEN,   32'd1,    NO_RES},
    '{ROW_TYPED, 2'd0, 32'h0A, '{1'b0, 12'sd0, 1'b1, 1'b1}},
    // magnitude above the bound
    '{ROW_WRITE, REG_SIG_LEN,   32'd3,    NO_RES},
    '{ROW_WRITE, REG_MAG_BOUND, 32'd4,    NO_RES},
    '{ROW_BEAT,  2'd0, 32'h0A, NO_RES},
    '{ROW_TYPED, 2'd0, 32'h01, '{1'b0, 12'sd0, 1'b1, 1'b0}},
    '{ROW_TYPED, 2'd0, 32'h00, '{1'b0, 12'sd0, 1'b1, 1'b1}},
    // zero bound still takes plus zero
    '{ROW_WRITE, REG_MAG_BOUND, 32'd0,    NO_RES},
    '{ROW_BEAT,  2'd0, 32'h00, NO_RES},
    '{ROW_TYPED, 2'd0, 32'h01, '{1'b1, 12'sd0, 1'b0, 1'b0}},
    '{ROW_TYPED, 2'd0, 32'h02, '{1'b1, 12'sd0, 1'b0, 1'b1}},
    // single coefficient with leftover bits set
    '{ROW_WRITE, REG_LOG_N,     32'd0,    NO_RES},
    '{ROW_WRITE, REG_SIG_LEN,   32'd2,    NO_RES},
    '{ROW_WRITE, REG_MAG_BOUND, 32'd2047, NO_RES},
    '{ROW_BEAT,  2'd0, 32'h0A, NO_RES},
    '{ROW_TYPED, 2'd0, 32'h03, '{1'b1, 12'sd5, 1'b1, 1'b1}},
    // largest magnitude the extra byte can close on an aligned header
    '{ROW_BEAT,  2'd0, 32'hFF, NO_RES},
    '{ROW_TYPED, 2'd0, 32'h80, '{1'b1, -12'sd1023, 1'b0, 1'b1}},
    // nonzero padding byte
    '{ROW_WRITE, REG_SIG_LEN,   32'd3,    NO_RES},
    '{ROW_BEAT,  2'd0, 32'h0A, NO_RES},
    '{ROW_TYPED, 2'd0, 32'h01, '{1'b1, 12'sd5, 1'b0, 1'b0}},
    '{ROW_TYPED, 2'd0, 32'h80, '{1'b0, 12'sd0, 1'b1, 1'b1}}
  };

  logic clk_i;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ccsd_in_if  byte_bus ();
  ccsd_out_if coef_bus ();

  compressed_coef_stream_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_bus),
    .coef_o  (coef_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register copies
  logic [LOG_N_W-1:0]   cfg_log_n;
  logic [SIG_LEN_W-1:0] cfg_sig_len;
  logic [MAG_W-1:0]     cfg_mag_bound;

  // decoder state as the block should hold it
  logic [15:0] dec_buf;
  logic [4:0]  dec_held;
  logic [10:0] dec_coefs;
  logic [11:0] dec_bytes;
  logic        dec_reject;
  logic        dec_run_open;

  ccsd_res_t   expected_decodes [$];
  int unsigned mismatches;
  int unsigned accepted_beats;
  int unsigned burst_left;
  int unsigned quiet_cycles;

  // message under construction
  bit          msg_bits [$];
  logic [7:0]  msg_bytes [$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_decode();
    dec_buf      = '0;
    dec_held     = '0;
    dec_coefs    = '0;
    dec_bytes    = '0;
    dec_reject   = 1'b0;
    dec_run_open = 1'b0;
  endfunction

  // one byte through the decoder: state update and the result it gives
  function automatic ccsd_res_t decode_byte(input logic [7:0] b);
    int unsigned ln, n, acc, len, sgn, mag, tz;
    bit          have, last;
    ccsd_res_t   r;
    ln   = (cfg_log_n > MAX_LOG_N_DEF) ? MAX_LOG_N_DEF : cfg_log_n;
    n    = 1 << ln;
    r    = '0;
    have = 1'b0;
    acc  = 0;
    sgn  = 0;
    mag  = 0;
    last = (12'(dec_bytes + 12'd1) == cfg_sig_len);
    if (!dec_reject) begin
      if (dec_coefs < n) begin
        len = dec_held & 5'd7;
        if (!dec_run_open) begin
          // header: sign and low magnitude, rest of the bits start the run
          acc = (32'(dec_buf) & 32'h7F) | (32'(b) << len);
          sgn = acc & 1;
          mag = (acc >> 1) & 32'h7F;
          acc = acc >> 8;
          if (acc == 0) begin
            dec_run_open = 1'b1;
            dec_buf      = 16'(sgn | (mag << 1));
            dec_held     = 5'(len);
          end else begin
            have = 1'b1;
          end
        end else begin
          // the extra byte must close the run
          sgn          = dec_buf[0];
          mag          = dec_buf[7:1];
          acc          = 32'(b) << len;
          len          = len + 8;
          dec_run_open = 1'b0;
          if (acc == 0) begin
            dec_reject = 1'b1;
          end else begin
            have = 1'b1;
          end
        end
        if (have) begin
          tz = 0;
          while (!acc[tz]) tz++;
          mag = mag + (tz << 7);
          if (mag > cfg_mag_bound || (mag == 0 && sgn != 0)) begin
            dec_reject = 1'b1;
          end else begin
            acc          = acc >> (tz + 1);
            dec_buf      = 16'(acc);
            dec_held     = 5'(len - tz - 1);
            dec_coefs    = dec_coefs + 11'd1;
            r.coef_valid = 1'b1;
            r.coef_value = 12'(sgn ? (0 - mag) : mag);
            if (dec_coefs == n && acc != 0) begin
              dec_reject = 1'b1;
            end
          end
        end
      end else if (b != 8'h00) begin
        dec_reject = 1'b1;
      end
    end
    dec_bytes = dec_bytes + 12'd1;
    if (last && dec_coefs < n) begin
      dec_reject = 1'b1;
    end
    r.rejected = dec_reject;
    r.msg_done = last;
    if (last) begin
      clear_decode();
    end
    return r;
  endfunction

  // register write over the config port
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_LOG_N:     cfg_log_n     = value[LOG_N_W-1:0];
      REG_SIG_LEN:   cfg_sig_len   = value[SIG_LEN_W-1:0];
      REG_MAG_BOUND: cfg_mag_bound = value[MAG_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one beat in, with bursts and gaps on the sender side
  task automatic send_byte(input logic [7:0] b, input bit typed, input ccsd_res_t typed_res);
    int unsigned gap;
    ccsd_res_t   predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        byte_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    byte_bus.valid   <= 1'b1;
    byte_bus.in_byte <= b;
    do @(posedge clk_i); while (!byte_bus.ready);
    predicted = decode_byte(b);
    expected_decodes.push_back(typed ? typed_res : predicted);
    accepted_beats++;
  endtask

  // sender holds off until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    byte_bus.valid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    burst_left = 0;
  endtask

  // encode 2^log_n random coefficients (log_n clamped), at times with a flaw, pad or truncate to sig_len, send them
  task automatic run_message(input bit fit_len);
    int unsigned n, cap, low_cap, mag, total, bad_at, flip_at, len;
    flaw_e       flaw;
    bit          sgn;
    logic [7:0]  b;
    n       = 1 << ((cfg_log_n > MAX_LOG_N_DEF) ? MAX_LOG_N_DEF : cfg_log_n);
    cap     = (cfg_mag_bound > 1023) ? 1023 : cfg_mag_bound;
    low_cap = (cap > 127) ? 127 : cap;
    flaw    = FLAW_NONE;
    if ($urandom_range(0, 19) >= 15) begin
      flaw = flaw_e'($urandom_range(FLAW_NOISE, FLAW_OVER_BOUND));
    end
    bad_at = $urandom_range(0, n - 1);
    msg_bits.delete();
    msg_bytes.delete();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0, 1:    mag = $urandom_range(0, low_cap);
        2:       mag = $urandom_range(0, cap);
        default: mag = cap;
      endcase
      sgn = (mag != 0) ? 1'($urandom_range(0, 1)) : 1'b0;
      if (i == bad_at && flaw == FLAW_MINUS_ZERO) begin
        sgn = 1'b1;
        mag = 0;
      end
      if (i == bad_at && flaw == FLAW_OVER_BOUND && cfg_mag_bound < 2047) begin
        mag = $urandom_range(cfg_mag_bound + 1, 2047);
      end
      // sign, seven low bits, then the high part in unary
      msg_bits.push_back(sgn);
      for (int k = 0; k < 7; k++) msg_bits.push_back(mag[k]);
      repeat (mag >> 7) msg_bits.push_back(1'b0);
      msg_bits.push_back(1'b1);
    end
    while (msg_bits.size() % 8 != 0) msg_bits.push_back(1'b0);
    for (int j = 0; j < msg_bits.size() / 8; j++) begin
      for (int k = 0; k < 8; k++) b[k] = msg_bits[8 * j + k];
      msg_bytes.push_back(b);
    end
    if (fit_len) begin
      len = msg_bytes.size() + $urandom_range(0, 3);
      cfg_write(REG_SIG_LEN, (len > 4095) ? 32'd4095 : 32'(len));
    end
    total   = (cfg_sig_len == 0) ? 4096 : cfg_sig_len;
    flip_at = $urandom_range(0, total - 1);
    for (int j = 0; j < total; j++) begin
      b = (j < msg_bytes.size()) ? msg_bytes[j] : 8'h00;
      case (flaw)
        FLAW_NOISE:    b = 8'($urandom_range(0, 255));
        FLAW_BIT_FLIP: if (j == flip_at) b = b ^ (8'h01 << $urandom_range(0, 7));
        FLAW_PADDING:  if (j == total - 1) b = b | (8'h01 << $urandom_range(0, 7));
        default: ;
      endcase
      send_byte(b, 1'b0, NO_RES);
    end
  endtask

  // receiver stall pattern: always ready, rotating pattern or random
  initial begin
    int unsigned stall_span;
    int unsigned stall_mode;
    logic [15:0] stall_pat;
    stall_span     = 0;
    stall_mode     = 0;
    stall_pat      = 16'hFFFF;
    coef_bus.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(16, 160);
        stall_pat  = 16'($urandom) | 16'h0001;
      end
      stall_span--;
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      case (stall_mode)
        0, 1:    coef_bus.ready <= 1'b1;
        2:       coef_bus.ready <= stall_pat[0];
        default: coef_bus.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    ccsd_res_t want;
    if (rst_ni && coef_bus.valid && coef_bus.ready) begin
      if (expected_decodes.size() == 0) begin
        $error("unexpected result beat: coef_valid %0b coef_value %0d",
               coef_bus.coef_valid, coef_bus.coef_value);
        mismatches++;
      end else begin
        want = expected_decodes.pop_front();
        if (coef_bus.coef_valid !== want.coef_valid) begin
          $error("coef_valid: expected %0b, got %0b", want.coef_valid, coef_bus.coef_valid);
          mismatches++;
        end
        if (coef_bus.coef_value !== want.coef_value) begin
          $error("coef_value: expected %0d, got %0d", want.coef_value, coef_bus.coef_value);
          mismatches++;
        end
        if (coef_bus.rejected !== want.rejected) begin
          $error("rejected: expected %0b, got %0b", want.rejected, coef_bus.rejected);
          mismatches++;
        end
        if (coef_bus.msg_done !== want.msg_done) begin
          $error("msg_done: expected %0b, got %0b", want.msg_done, coef_bus.msg_done);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_bus.valid && byte_bus.ready) || (coef_bus.valid && coef_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("compressed_coef_stream_decoder test failed");
      $finish;
    end
  end

  initial begin
    int unsigned beats_goal;
    int unsigned bound;
    rst_ni           = 1'b0;
    byte_bus.valid   = 1'b0;
    byte_bus.in_byte = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    mismatches       = 0;
    accepted_beats   = 0;
    burst_left       = 0;
    quiet_cycles     = 0;
    cfg_log_n        = LOG_N_RST;
    cfg_sig_len      = SIG_LEN_RST;
    cfg_mag_bound    = MAG_BOUND_RST;
    clear_decode();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      case (DIRECTED[i].kind)
        ROW_WRITE: begin
          drain_results();
          cfg_write(DIRECTED[i].reg_idx, DIRECTED[i].value);
        end
        ROW_TYPED: send_byte(DIRECTED[i].value[7:0], 1'b1, DIRECTED[i].res);
        default:   send_byte(DIRECTED[i].value[7:0], 1'b0, NO_RES);
      endcase
    end

    // random settings, one message each and up to four more for small log_n, mostly well formed
    beats_goal = accepted_beats + RANDOM_BEATS;
    while (accepted_beats < beats_goal) begin
      drain_results();
      cfg_write(REG_LOG_N, ($urandom_range(0, 39) == 0) ? $urandom_range(6, 15)
                                                        : $urandom_range(0, 5));
      case ($urandom_range(0, 3))
        0:       bound = 2047;
        1:       bound = $urandom_range(0, 2047);
        2:       bound = $urandom_range(128, 1023);
        default: bound = $urandom_range(0, 127);
      endcase
      cfg_write(REG_MAG_BOUND, 32'(bound));
      run_message(1'b1);
      if (cfg_log_n <= 6) begin
        repeat ($urandom_range(1, 4)) run_message(1'b0);
      end
    end

    // full size: log_n past the maximum, small magnitudes keep the message short
    drain_results();
    cfg_write(REG_LOG_N, 32'd15);
    cfg_write(REG_MAG_BOUND, 32'd127);
    run_message(1'b1);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("compressed_coef_stream_decoder test passed");
    end else begin
      $display("compressed_coef_stream_decoder test failed");
    end
    $finish;
  end

endmodule
